/* rtl/core/see_pkg.sv */
package see_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ESCAPE_BRACKETS = 1'b0;
  localparam logic CFG_JSON_MODE       = 1'b1;

  // Queue geometry
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Step counter inside one escape sequence (longest sequence is six bytes)
  localparam int IDX_W = 3;

  // ASCII characters used by the escape sequences
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_RBRACKET  = 8'h5d;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_DEL       = 8'h7f;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Classified operation carried from front to back
  typedef enum logic [2:0] {
    OP_QUOTE   = 3'd0,  // a single double quote
    OP_NAMED   = 3'd1,  // backslash plus letter
    OP_HEX_X   = 3'd2,  // backslash x hh
    OP_HEX_U   = 3'd3,  // backslash u 00hh
    OP_BRACKET = 3'd4,  // [ " [ " ]
    OP_LITERAL = 3'd5   // the byte itself
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;   // letter for named escapes, source byte otherwise
  } entry_t;

endpackage

/* rtl/core/see_front.sv */
module see_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               in_fire,
  input  logic [1:0]         kind,
  input  logic [7:0]         char_byte,
  output logic               push,
  output see_pkg::entry_t    push_entry
);
  import see_pkg::*;

  logic       escape_brackets;
  logic       json_mode;
  logic [7:0] letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_brackets <= 1'b0;
      json_mode       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESCAPE_BRACKETS: escape_brackets <= cfg_data;
        CFG_JSON_MODE:       json_mode       <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Named escape letter, zero when the byte has none
  always_comb begin
    unique case (char_byte)
      8'h07:        letter = 8'h61;  // a
      8'h08:        letter = 8'h62;  // b
      8'h0c:        letter = 8'h66;  // f
      8'h0a:        letter = 8'h6e;  // n
      8'h0d:        letter = 8'h72;  // r
      8'h09:        letter = 8'h74;  // t
      8'h0b:        letter = 8'h76;  // v
      CH_QUOTE:     letter = CH_QUOTE;
      CH_BACKSLASH: letter = CH_BACKSLASH;
      default:      letter = 8'h00;
    endcase
  end

  // Classify; kind three and NUL bytes produce nothing
  always_comb begin
    push            = 1'b0;
    push_entry.op   = OP_LITERAL;
    push_entry.data = char_byte;
    priority if (kind == KIND_OPEN || kind == KIND_CLOSE) begin
      push          = in_fire;
      push_entry.op = OP_QUOTE;
    end else if (kind == KIND_DATA && char_byte != 8'h00) begin
      push = in_fire;
      priority if (letter != 8'h00) begin
        push_entry.op   = OP_NAMED;
        push_entry.data = letter;
      end else if (char_byte < CH_SPACE || char_byte == CH_DEL) begin
        push_entry.op = json_mode ? OP_HEX_U : OP_HEX_X;
      end else if (escape_brackets && char_byte == CH_LBRACKET) begin
        push_entry.op = OP_BRACKET;
      end else begin
        push_entry.op = OP_LITERAL;
      end
    end else begin
      push = 1'b0;
    end
  end

endmodule

/* rtl/core/see_queue.sv */
module see_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  see_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output see_pkg::entry_t head
);
  import see_pkg::*;

  entry_t             slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

/* rtl/core/see_back.sv */
module see_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  see_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import see_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] seq_len;
  logic [7:0]       seq_byte;
  logic [7:0]       hi_digit;
  logic [7:0]       lo_digit;
  logic             seq_last;
  logic             load;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
  endfunction

  assign hi_digit = hex_char(head.data[7:4]);
  assign lo_digit = hex_char(head.data[3:0]);

  always_comb begin
    unique case (head.op)
      OP_QUOTE:   seq_len = IDX_W'(1);
      OP_NAMED:   seq_len = IDX_W'(2);
      OP_HEX_X:   seq_len = IDX_W'(4);
      OP_HEX_U:   seq_len = IDX_W'(6);
      OP_BRACKET: seq_len = IDX_W'(5);
      OP_LITERAL: seq_len = IDX_W'(1);
      default:    seq_len = IDX_W'(1);
    endcase
  end

  always_comb begin
    seq_byte = head.data;
    unique case (head.op)
      OP_QUOTE:   seq_byte = CH_QUOTE;
      OP_NAMED:   seq_byte = (idx == '0) ? CH_BACKSLASH : head.data;
      OP_HEX_X: begin
        unique case (idx)
          IDX_W'(0): seq_byte = CH_BACKSLASH;
          IDX_W'(1): seq_byte = CH_X;
          IDX_W'(2): seq_byte = hi_digit;
          default:   seq_byte = lo_digit;
        endcase
      end
      OP_HEX_U: begin
        unique case (idx)
          IDX_W'(0): seq_byte = CH_BACKSLASH;
          IDX_W'(1): seq_byte = CH_U;
          IDX_W'(2): seq_byte = CH_ZERO;
          IDX_W'(3): seq_byte = CH_ZERO;
          IDX_W'(4): seq_byte = hi_digit;
          default:   seq_byte = lo_digit;
        endcase
      end
      OP_BRACKET: begin
        unique case (idx)
          IDX_W'(0): seq_byte = CH_LBRACKET;
          IDX_W'(1): seq_byte = CH_QUOTE;
          IDX_W'(2): seq_byte = CH_LBRACKET;
          IDX_W'(3): seq_byte = CH_QUOTE;
          default:   seq_byte = CH_RBRACKET;
        endcase
      end
      OP_LITERAL: seq_byte = head.data;
      default:    seq_byte = head.data;
    endcase
  end

  assign seq_last = (idx == seq_len - IDX_W'(1));
  assign load     = not_empty && (!out_valid || !out_stall);
  assign pop      = load && seq_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= seq_byte;
      last_of_run <= seq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= seq_last ? '0 : idx + IDX_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/string_escape_encoder.sv */
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------
// input     | in_valid / in_stall | kind[1:0], char_byte[7:0]
// output    | out_valid/out_stall | out_byte[7:0], last_of_run
// config    | cfg_we              | cfg_index (0 brackets, 1 json), cfg_data
//
// One output byte per cycle unless out_stall holds the output or the queue is
// empty; an item expands to 1 to 6 bytes, counted by the back-end sequencer;
// an item with no bytes (kind three, NUL data) never enters the queue. Data
// passes the queue, then the output register. Synchronous reset clears queue,
// sequencer and config. in_stall rises only when the two-entry queue is full;
// out_stall holds the output register and, behind it, the queue.
module string_escape_encoder (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] char_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import see_pkg::*;

  logic   in_fire;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_full;
  logic   q_not_empty;
  entry_t q_head;

  // Take an input transfer whenever the queue has room
  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  // Front: hold the config bits and classify each byte into an operation
  see_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .kind       (kind),
    .char_byte  (char_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue decouples classification from expansion
  see_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back: advance through the escape sequence of the queue head, one byte
  // per output transfer, and drop the entry after its last byte
  see_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (q_not_empty),
    .head        (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

/* rtl/core/see_checker.sv */
module see_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // Held output stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output changed while stalled");

  // Reset empties both the queue and the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // A byte that is not the end of a run belongs to an escape sequence prefix
  a_mid_run_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |->
      out_byte == 8'h5c || out_byte == 8'h78 || out_byte == 8'h75 ||
      out_byte == 8'h5b || out_byte == 8'h22 ||
      (out_byte >= 8'h30 && out_byte <= 8'h37))
    else $error("unexpected byte inside an escape sequence");

endmodule

bind string_escape_encoder see_checker u_see_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
